// File: design/pmt_pkg.sv
// Shared types and constants for the peer record table.
// No dependencies; used by every module of the block.
`default_nettype none
package pmt_pkg;
  localparam int unsigned SLOTS = 16;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [31:0] ALL_EVENTS = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    FN_PERSIST = 3'd0,
    FN_SEEN    = 3'd1,
    FN_SUBS    = 3'd2,
    FN_WANTS   = 3'd3,
    FN_FORGET  = 3'd4,
    FN_LOOKUP  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_EXEC = 2'd2,
    S_OUT  = 2'd3
  } state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [47:0] mac;
    logic [7:0]  mesh_id;
    logic [63:0] pub_word0;
    logic [63:0] pub_word1;
    logic [63:0] pub_word2;
    logic [63:0] pub_word3;
    logic [31:0] bonded_at_sec;
    logic [31:0] now_sec;
    logic [31:0] event_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic        wants;
    logic [7:0]  out_mesh_id;
    logic [63:0] out_pub0;
    logic [63:0] out_pub1;
    logic [63:0] out_pub2;
    logic [63:0] out_pub3;
    logic [31:0] out_bonded;
    logic [31:0] out_last_seen;
    logic [31:0] out_subscriptions;
  } out_item_t;

  typedef struct packed {
    logic load;   // capture input beat, reset scan
    logic step;   // examine one slot
    logic exec;   // apply operation, build result
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;
endpackage
`default_nettype wire

// File: design/pmt_ctrl.sv
// Controller for the peer record table: sequences capture, scan, execute, output.
// Depends on pmt_pkg.
`default_nettype none
module pmt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire pmt_pkg::sts_t sts,
  output pmt_pkg::cmd_t      cmd
);
  pmt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= pmt_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      pmt_pkg::S_IDLE: if (in_valid) state_next = pmt_pkg::S_SCAN;
      pmt_pkg::S_SCAN: if (sts.scan_done) state_next = pmt_pkg::S_EXEC;
      pmt_pkg::S_EXEC: state_next = pmt_pkg::S_OUT;
      pmt_pkg::S_OUT:  if (out_ready) state_next = pmt_pkg::S_IDLE;
      default:         state_next = pmt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == pmt_pkg::S_IDLE);
    out_valid = (state == pmt_pkg::S_OUT);
    cmd.load  = (state == pmt_pkg::S_IDLE) && in_valid;
    cmd.step  = (state == pmt_pkg::S_SCAN) && !sts.scan_done;
    cmd.exec  = (state == pmt_pkg::S_EXEC);
  end

  ap_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready and valid together");
  ap_exec_out: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid) else $error("exec not followed by result");
  ap_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule
`default_nettype wire

// File: design/pmt_datapath.sv
// Datapath of the peer record table: slot registers, serial scan, update, result.
// Depends on pmt_pkg.
`default_nettype none
module pmt_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pmt_pkg::cmd_t     cmd,
  output pmt_pkg::sts_t          sts,
  input  wire pmt_pkg::in_item_t in_item,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_data,
  output pmt_pkg::out_item_t     out_item
);
  localparam int unsigned N = pmt_pkg::SLOTS;
  localparam int unsigned SW = pmt_pkg::SLOT_W;
  localparam int unsigned CW = pmt_pkg::CNT_W;

  logic [N-1:0]     valid;
  logic [47:0]      smac  [N];
  logic [7:0]       smesh [N];
  logic [255:0]     skey  [N];
  logic [31:0]      sbond [N];
  logic [31:0]      sseen [N];
  logic [31:0]      smask [N];
  logic [31:0]      default_subscription;

  pmt_pkg::in_item_t  item;
  pmt_pkg::out_item_t result;
  pmt_pkg::out_item_t result_next;
  logic [CW-1:0] cnt;
  logic [SW-1:0] cur;
  logic          hit_found, free_found;
  logic [SW-1:0] hit_idx, free_idx;

  assign cur = cnt[SW-1:0];
  assign sts.scan_done = (cnt == CW'(N));
  assign out_item = result;

  always_ff @(posedge clk) begin
    if (rst) default_subscription <= pmt_pkg::ALL_EVENTS;
    else if (cfg_we) default_subscription <= cfg_data;
  end

  // Serial scan: one slot per cycle, the first hit and the first free slot are kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      item       <= in_item;
      cnt        <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      hit_idx    <= '0;
      free_idx   <= '0;
    end else if (cmd.step) begin
      cnt <= cnt + CW'(1);
      if (!hit_found && valid[cur] && smac[cur] == item.mac) begin
        hit_found <= 1'b1;
        hit_idx   <= cur;
      end
      if (!free_found && !valid[cur]) begin
        free_found <= 1'b1;
        free_idx   <= cur;
      end
    end
  end

  logic [SW-1:0] idx;
  logic          fresh;
  assign idx   = hit_found ? hit_idx : free_idx;
  assign fresh = !hit_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.exec) begin
      case (item.func)
        pmt_pkg::FN_PERSIST: if (hit_found || free_found) valid[idx] <= 1'b1;
        pmt_pkg::FN_FORGET:  if (hit_found) valid[hit_idx] <= 1'b0;
        default: ;
      endcase
    end
  end

  // Record payload; cleared with the valid bit so a forgotten slot reads zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        smac[i] <= '0; smesh[i] <= '0; skey[i] <= '0;
        sbond[i] <= '0; sseen[i] <= '0; smask[i] <= '0;
      end
    end else if (cmd.exec) begin
      case (item.func)
        pmt_pkg::FN_PERSIST: if (hit_found || free_found) begin
          smac[idx]  <= item.mac;
          smesh[idx] <= item.mesh_id;
          skey[idx]  <= {item.pub_word0, item.pub_word1, item.pub_word2, item.pub_word3};
          if (fresh || sbond[idx] == 32'd0) sbond[idx] <= item.bonded_at_sec;
          sseen[idx] <= item.now_sec;
          if (fresh) smask[idx] <= default_subscription;
        end
        pmt_pkg::FN_SEEN: if (hit_found) sseen[hit_idx] <= item.now_sec;
        pmt_pkg::FN_SUBS: if (hit_found) smask[hit_idx] <= item.event_mask;
        pmt_pkg::FN_FORGET: if (hit_found) begin
          smac[hit_idx] <= '0; smesh[hit_idx] <= '0; skey[hit_idx] <= '0;
          sbond[hit_idx] <= '0; sseen[hit_idx] <= '0; smask[hit_idx] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result_next = '0;
    case (item.func)
      pmt_pkg::FN_PERSIST: begin
        if (hit_found || free_found) result_next.slot = 4'(idx);
        else result_next.status = pmt_pkg::ST_FULL;
      end
      pmt_pkg::FN_SEEN, pmt_pkg::FN_SUBS, pmt_pkg::FN_FORGET: begin
        if (hit_found) result_next.slot = 4'(hit_idx);
        else result_next.status = pmt_pkg::ST_UNKNOWN;
      end
      pmt_pkg::FN_WANTS: begin
        if (hit_found) begin
          result_next.slot  = 4'(hit_idx);
          result_next.wants = |(smask[hit_idx] & item.event_mask);
        end else begin
          result_next.status = pmt_pkg::ST_UNKNOWN;
          result_next.wants  = 1'b1;
        end
      end
      pmt_pkg::FN_LOOKUP: begin
        if (hit_found) begin
          result_next.slot              = 4'(hit_idx);
          result_next.out_mesh_id       = smesh[hit_idx];
          result_next.out_pub0          = skey[hit_idx][255:192];
          result_next.out_pub1          = skey[hit_idx][191:128];
          result_next.out_pub2          = skey[hit_idx][127:64];
          result_next.out_pub3          = skey[hit_idx][63:0];
          result_next.out_bonded        = sbond[hit_idx];
          result_next.out_last_seen     = sseen[hit_idx];
          result_next.out_subscriptions = smask[hit_idx];
        end else begin
          result_next.status = pmt_pkg::ST_UNKNOWN;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) result <= result_next;
  end

  ap_hit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && hit_found |-> valid[hit_idx]) else $error("hit on invalid slot");
  ap_free_invalid: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && free_found |-> !valid[free_idx]) else $error("free slot is valid");
  ap_cnt: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(N)) else $error("scan counter overrun");
endmodule
`default_nettype wire

// File: design/peer_mac_table_with_subscriptions_unit.sv
// Top level of the peer record table: joins controller and datapath.
// Depends on pmt_pkg, pmt_ctrl and pmt_datapath.
//
// Usage: an operation beat enters on in_valid/in_ready with an in_item_t
// payload; exactly one result beat leaves on out_valid/out_ready.
// The table is searched by MAC one slot per clock. After the input beat
// is accepted, the controller passes through S_SCAN, which steps over
// every slot and then sees the scan end, and S_EXEC, which registers
// the result; out_valid rises in S_OUT.
// One item is in flight at a time; in_ready returns the cycle after the
// result beat is taken, so no new item is accepted before the last
// result has left.
// If the receiver stalls, the result holds in its register and no new
// operation is taken until it goes.
// Synchronous reset empties every slot and sets the default subscription
// to all ones. cfg_we writes the default subscription in the same cycle.
`default_nettype none
module peer_mac_table_with_subscriptions_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pmt_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pmt_pkg::out_item_t     out_data,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_data
);
  pmt_pkg::cmd_t cmd;
  pmt_pkg::sts_t sts;

  pmt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  pmt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .in_item(in_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .out_item(out_data)
  );
endmodule
`default_nettype wire
